// ----- rtl/np2r_pkg.sv -----
// Package for the nearest power-of-two recoder.
// Holds widths, reset values, term kind codes, sequencer states and the step flag struct.
// No dependencies.
package np2r_pkg;

  // Default width of the constant magnitude.
  localparam int unsigned VALUE_BITS_DEF = 31;

  // Configuration register.
  localparam int unsigned CFG_W           = 7;
  localparam logic [6:0]  MAX_TERMS_RESET = 7'd64;

  // At most this many beats per run: terms plus the end beat.
  localparam int unsigned MAX_RESULTS = 33;
  localparam int unsigned TERM_LIMIT  = MAX_RESULTS - 1;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS);

  // Result field widths.
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned SHIFT_W = 5;

  // APB port geometry: one 32-bit register at byte address 0.
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned REG_IDX_W = APB_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_TERMS = '0;

  // Term kind codes.
  typedef enum logic [KIND_W-1:0] {
    KIND_ADD   = 2'd0,
    KIND_SUB   = 2'd1,
    KIND_EXACT = 2'd2,
    KIND_END   = 2'd3
  } term_kind_e;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_e;

  // Classification of the current remainder by the step unit.
  typedef struct packed {
    logic is_zero;
    logic is_one;
    logic is_exact;
    logic take_lower;
  } step_flags_t;

endpackage

// ----- rtl/np2r_step.sv -----
// Shared recoding step unit: classifies one remainder and forms the next one.
// Finds the highest set bit, picks the nearer bracketing power (lower on a tie).
// Depends on np2r_pkg.
module np2r_step import np2r_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  parameter int unsigned EXP_W      = $clog2(VALUE_BITS + 1)
) (
  input  logic [VALUE_BITS-1:0] rem_i,
  output logic [EXP_W-1:0]      exp_o,
  output logic [VALUE_BITS-1:0] next_rem_o,
  output step_flags_t           flags_o
);

  logic [VALUE_BITS-1:0] low_pwr;
  logic [VALUE_BITS-1:0] rest;
  logic [VALUE_BITS:0]   high_pwr;
  logic [VALUE_BITS:0]   high_gap;

  // Leading-one position; bit 0 only matters for remainders below two,
  // which are handled as special cases.
  always_comb begin
    exp_o = '0;
    for (int i = 1; i < VALUE_BITS; i++) begin
      if (rem_i[i]) begin
        exp_o = EXP_W'(i);
      end
    end
  end

  // Distances to the two bracketing powers.
  assign low_pwr  = VALUE_BITS'(1) << exp_o;
  assign rest     = rem_i ^ low_pwr;
  assign high_pwr = {1'b0, low_pwr} << 1;
  assign high_gap = high_pwr - {1'b0, rem_i};

  // The lower power wins when the remainder above it is at most half of it.
  always_comb begin
    flags_o.is_zero    = (rem_i == '0);
    flags_o.is_one     = (rem_i == VALUE_BITS'(1));
    flags_o.is_exact   = (rest == '0);
    flags_o.take_lower = (rest <= (low_pwr >> 1));
  end

  // An exact power leaves a zero remainder through the lower branch.
  assign next_rem_o = flags_o.take_lower ? rest : high_gap[VALUE_BITS-1:0];

endmodule

// ----- rtl/nearest_power_of_two_recoder.sv -----
// Top level of the nearest power-of-two recoder: APB register, sequencer and result beats.
// Instantiates np2r_step and depends on np2r_pkg.
//
// Usage:
//   Pulse start with magnitude while busy is low; the beat is taken at that edge.
//   The block then emits one result beat per cycle on term_kind_o, shift_amount_o,
//   plus_one_o, too_expensive_o and last_o, each marked by result_valid_o for one
//   cycle. Term beats come first; a closing end beat (kind 3, last_o high) carries
//   the plus-one and too-expensive flags.
//   Timing: the accepting edge loads the remainder register and enters the run
//   state; each beat is then formed by one pass of the shared step unit and held
//   in the result registers while it is shown. Each pass lowers the leading-one
//   position by at least one, so a 31-bit magnitude gives at most 30 terms.
//   busy falls with the end beat, so the next start can be taken in the cycle
//   that shows the end beat.
//   The receiver cannot stall; every beat must be taken when shown.
//   max_terms sits at APB byte address 0 and resets to 64; write it only while
//   busy is low. Reset clears the sequencer and the result strobe at once.
module nearest_power_of_two_recoder import np2r_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Command channel
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] magnitude_i,
  // Result channel
  output logic                  result_valid_o,
  output logic [KIND_W-1:0]     term_kind_o,
  output logic [SHIFT_W-1:0]    shift_amount_o,
  output logic                  plus_one_o,
  output logic                  too_expensive_o,
  output logic                  last_o,
  // APB configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready
);

  localparam int unsigned EXP_W = $clog2(VALUE_BITS + 1);

  state_e                state_q, state_d;
  logic [VALUE_BITS-1:0] rem_q, rem_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CFG_W-1:0]      max_terms_q;

  logic                  vld_q, vld_d;
  term_kind_e            kind_q, kind_d;
  logic [SHIFT_W-1:0]    shift_q, shift_d;
  logic                  p1_q, p1_d;
  logic                  te_q, te_d;
  logic                  last_q, last_d;

  logic                  accept;
  logic                  cap_hit;
  logic [EXP_W-1:0]      step_exp;
  logic [EXP_W-1:0]      step_exp_up;
  logic [VALUE_BITS-1:0] step_next;
  step_flags_t           step_flags;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[APB_AW-1:2] == REG_MAX_TERMS) ? APB_DW'(max_terms_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_terms_q <= MAX_TERMS_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[APB_AW-1:2] == REG_MAX_TERMS)) begin
      max_terms_q <= pwdata[CFG_W-1:0];
    end
  end

  // Shared step unit, fed from the remainder register.
  np2r_step #(
    .VALUE_BITS (VALUE_BITS),
    .EXP_W      (EXP_W)
  ) u_step (
    .rem_i      (rem_q),
    .exp_o      (step_exp),
    .next_rem_o (step_next),
    .flags_o    (step_flags)
  );

  assign step_exp_up = step_exp + 1'b1;
  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cap_hit     = (CFG_W'(cnt_q) >= max_terms_q) || (cnt_q >= CNT_W'(TERM_LIMIT));

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_flags.is_zero || step_flags.is_one || cap_hit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and result beat for the current step.
  always_comb begin
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    vld_d   = 1'b0;
    kind_d  = KIND_END;
    shift_d = '0;
    p1_d    = 1'b0;
    te_d    = 1'b0;
    last_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rem_d = magnitude_i;
          cnt_d = '0;
        end
      end
      ST_RUN: begin
        vld_d = 1'b1;
        if (step_flags.is_zero || step_flags.is_one || cap_hit) begin
          // Closing end beat; small remainders take priority over the cap.
          last_d = 1'b1;
          p1_d   = step_flags.is_one;
          te_d   = !step_flags.is_zero && !step_flags.is_one;
        end else begin
          rem_d = step_next;
          cnt_d = cnt_q + 1'b1;
          if (step_flags.is_exact) begin
            kind_d  = KIND_EXACT;
            shift_d = SHIFT_W'(step_exp);
          end else if (step_flags.take_lower) begin
            kind_d  = KIND_ADD;
            shift_d = SHIFT_W'(step_exp);
          end else begin
            kind_d  = KIND_SUB;
            shift_d = SHIFT_W'(step_exp_up);
          end
        end
      end
      default: begin
        vld_d = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vld_q   <= 1'b0;
      rem_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    shift_q <= shift_d;
    p1_q    <= p1_d;
    te_q    <= te_d;
    last_q  <= last_d;
  end

  assign result_valid_o  = vld_q;
  assign term_kind_o     = kind_q;
  assign shift_amount_o  = shift_q;
  assign plus_one_o      = p1_q;
  assign too_expensive_o = te_q;
  assign last_o          = last_q;

  // A result beat carries last exactly when it is the end beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (last_o == (term_kind_o == KIND_END)))
    else $error("last does not match the end beat");

  // Term beats never carry the end-only flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> (!plus_one_o && !too_expensive_o))
    else $error("end flags set on a term beat");

  // An accepted command makes the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("command accepted without going busy");

  // The run ends together with its end beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (result_valid_o && last_o))
    else $error("busy dropped without an end beat");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the nearest power-of-two recoder.
// Predicts every term and end beat in step with accepted commands; needs np2r_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top import np2r_pkg::*; ();

  // One expected result beat.
  typedef struct {
    term_kind_e       kind;
    logic [SHIFT_W-1:0] shift;
    logic             plus_one;
    logic             too_expensive;
    logic             last;
  } recode_beat_t;

  localparam logic [APB_AW-1:0] MAX_TERMS_ADDR = {REG_MAX_TERMS, 2'b00};
  localparam int unsigned       MAG_W          = VALUE_BITS_DEF;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [MAG_W-1:0]   magnitude_i = '0;
  logic               result_valid_o;
  logic [KIND_W-1:0]  term_kind_o;
  logic [SHIFT_W-1:0] shift_amount_o;
  logic               plus_one_o;
  logic               too_expensive_o;
  logic               last_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [APB_AW-1:0]  paddr = '0;
  logic [APB_DW-1:0]  pwdata = '0;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  // Predictor state: the term cap as last written, and the beats still owed.
  logic [CFG_W-1:0]   cap_max_terms = MAX_TERMS_RESET;
  recode_beat_t       expected_beats[$];
  int                 mismatch_count = 0;
  bit                 back_to_back = 1'b0;

  nearest_power_of_two_recoder u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .magnitude_i    (magnitude_i),
    .result_valid_o (result_valid_o),
    .term_kind_o    (term_kind_o),
    .shift_amount_o (shift_amount_o),
    .plus_one_o     (plus_one_o),
    .too_expensive_o(too_expensive_o),
    .last_o         (last_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #2 clk_i = ~clk_i;

  // Queues one expected beat.
  function automatic void push_beat(term_kind_e kind, int shift, logic p1, logic te);
    recode_beat_t b;
    b.kind          = kind;
    b.shift         = shift[SHIFT_W-1:0];
    b.plus_one      = p1;
    b.too_expensive = te;
    b.last          = (kind == KIND_END);
    expected_beats  = {expected_beats, b};
  endfunction

  // Greedy nearest-power recoding of one magnitude under the current cap.
  function automatic void predict_recoding(logic [MAG_W-1:0] mag);
    logic [31:0] rem;
    logic [31:0] base_pwr;
    logic [31:0] below_gap;
    logic [31:0] above_gap;
    int          lo;
    int          terms;
    logic        p1;
    logic        te;
    bit          done;
    rem   = {1'b0, mag};
    terms = 0;
    p1    = 1'b0;
    te    = 1'b0;
    done  = 1'b0;
    while (!done) begin
      if (rem == 0) begin
        done = 1'b1;
      end else if (rem == 1) begin
        p1   = 1'b1;
        done = 1'b1;
      end else if (terms >= int'(cap_max_terms) || terms >= int'(TERM_LIMIT)) begin
        te   = 1'b1;
        done = 1'b1;
      end else begin
        lo = 0;
        for (int i = 0; i < 32; i++) begin
          if (rem[i]) lo = i;
        end
        base_pwr = 32'd1 << lo;
        if (rem == base_pwr) begin
          push_beat(KIND_EXACT, lo, 1'b0, 1'b0);
          done = 1'b1;
        end else begin
          below_gap = rem - base_pwr;
          above_gap = (base_pwr << 1) - rem;
          // A tie goes to the lower power.
          if (below_gap <= above_gap) begin
            push_beat(KIND_ADD, lo, 1'b0, 1'b0);
            rem = below_gap;
          end else begin
            push_beat(KIND_SUB, lo + 1, 1'b0, 1'b0);
            rem = above_gap;
          end
        end
        terms++;
      end
    end
    push_beat(KIND_END, 0, p1, te);
  endfunction

  // Result checker and command monitor, both sampled at the rising edge.
  always @(posedge clk_i) begin : result_check
    recode_beat_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected: kind %0d shift %0d",
                 term_kind_o, shift_amount_o);
          mismatch_count++;
        end else begin
          want = expected_beats.pop_front();
          if (term_kind_o !== want.kind) begin
            $error("term_kind expected %0d got %0d", want.kind, term_kind_o);
            mismatch_count++;
          end
          if (shift_amount_o !== want.shift) begin
            $error("shift_amount expected %0d got %0d", want.shift, shift_amount_o);
            mismatch_count++;
          end
          if (plus_one_o !== want.plus_one) begin
            $error("plus_one expected %0d got %0d", want.plus_one, plus_one_o);
            mismatch_count++;
          end
          if (too_expensive_o !== want.too_expensive) begin
            $error("too_expensive expected %0d got %0d", want.too_expensive,
                   too_expensive_o);
            mismatch_count++;
          end
          if (last_o !== want.last) begin
            $error("last expected %0d got %0d", want.last, last_o);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) predict_recoding(magnitude_i);
    end
  end

  // Sends one magnitude, then idles for a random gap, or not at all when back_to_back is set.
  task automatic send_magnitude(input logic [MAG_W-1:0] mag);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, 17);
    start       <= 1'b1;
    magnitude_i <= mag;
    do @(posedge clk_i); while (busy);
    if (gap > 0) begin
      start       <= 1'b0;
      magnitude_i <= MAG_W'($urandom());
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Lowers start and waits until every owed beat has come out. The first edge
  // lets a command taken at the previous edge show up as busy and owed beats.
  task automatic settle_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_beats.size() != 0 || busy) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Writes max_terms through APB, then reads it back.
  task automatic write_max_terms(input logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAX_TERMS_ADDR;
    pwdata  <= ($urandom() & ~32'h7F) | APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    cap_max_terms = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== APB_DW'(cap_max_terms)) begin
      $error("prdata expected %0d got %0d", cap_max_terms, prdata);
      mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random magnitude: mostly narrow values, plus full-width values, ties and near-powers.
  function automatic logic [MAG_W-1:0] rand_magnitude();
    int sel;
    int k;
    sel = $urandom_range(0, 9);
    k   = $urandom_range(0, 29);
    case (sel)
      0: return MAG_W'(32'd3 << k);
      1: return MAG_W'((32'd1 << (k + 1)) + $urandom_range(0, 3) - 2);
      2, 3: return MAG_W'($urandom());
      default: return MAG_W'($urandom() & ((32'd1 << $urandom_range(1, MAG_W)) - 1));
    endcase
  endfunction

  // Default cap: extremes of the magnitude, ties, exact powers, long runs.
  task automatic test_directed_values();
    logic [MAG_W-1:0] vals[$];
    vals = {31'd0, 31'd1, 31'd2, 31'd3, 31'd6, 31'd7, 31'd11,
            31'h4000_0000, 31'h7FFF_FFFF, 31'h5555_5555, 31'h2AAA_AAAB, 31'h6000_0000};
    settle_idle();
    write_max_terms(MAX_TERMS_RESET);
    foreach (vals[i]) send_magnitude(vals[i]);
  endtask

  // Caps of zero, one, two and above range.
  task automatic test_cap_extremes();
    logic [CFG_W-1:0] caps[$];
    logic [MAG_W-1:0] vals[$];
    caps = {7'd0, 7'd1, 7'd2, 7'd127};
    vals = {31'd1, 31'd4, 31'h2AAA_AAAB};
    foreach (caps[c]) begin
      settle_idle();
      write_max_terms(caps[c]);
      foreach (vals[i]) send_magnitude(vals[i]);
    end
  endtask

  // Random magnitudes over several caps, with idle-free stretches and drains.
  task automatic test_random_recoding();
    logic [CFG_W-1:0] cap;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: cap = 7'd64;
        1: cap = 7'd1;
        2: cap = 7'($urandom_range(2, 63));
        3: cap = 7'd127;
        default: cap = 7'($urandom_range(0, 127));
      endcase
      settle_idle();
      write_max_terms(cap);
      back_to_back = (phase == 2);
      for (int n = 0; n < 49; n++) begin
        if ($urandom_range(0, 29) == 0) back_to_back = !back_to_back;
        if ($urandom_range(0, 19) == 0) settle_idle();
        send_magnitude(rand_magnitude());
      end
    end
    back_to_back = 1'b0;
  endtask

  // Test sequence and final verdict.
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_values();
    test_cap_extremes();
    test_random_recoding();
    settle_idle();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && expected_beats.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
